// ===== sv/lhfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and header helper functions for the L4 header field matcher.
// No dependencies; the core, cfg, parser and decide files refer to this package by scoped names.
package lhfm_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned NUM_RULES        = 3;
  localparam int unsigned NUM_CFG_REGS     = 2 * NUM_RULES;
  localparam int unsigned APB_DATA_W       = 64;
  localparam int unsigned APB_ADDR_W       = 6;
  localparam int unsigned GATHER_W         = 32;

  // Parse phases
  localparam logic [2:0] PH_IP     = 3'd0;
  localparam logic [2:0] PH_WALK   = 3'd1;
  localparam logic [2:0] PH_EXTLEN = 3'd2;
  localparam logic [2:0] PH_L4     = 3'd3;
  localparam logic [2:0] PH_DEAD   = 3'd4;

  // Protocol numbers
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_SCTP = 8'd132;

  // IPv6 extension header types
  localparam logic [7:0] EH_HOPOPT   = 8'd0;
  localparam logic [7:0] EH_ROUTING  = 8'd43;
  localparam logic [7:0] EH_FRAG     = 8'd44;
  localparam logic [7:0] EH_ESP      = 8'd50;
  localparam logic [7:0] EH_AH       = 8'd51;
  localparam logic [7:0] EH_DSTOPT   = 8'd60;
  localparam logic [7:0] EH_MOBILITY = 8'd135;
  localparam logic [7:0] EH_HIP      = 8'd139;
  localparam logic [7:0] EH_SHIM6    = 8'd140;
  localparam logic [7:0] EH_EXP1     = 8'd253;
  localparam logic [7:0] EH_EXP2     = 8'd254;

  // Rule protocol codes
  localparam logic [1:0] CODE_OFF  = 2'd0;
  localparam logic [1:0] CODE_SCTP = 2'd1;
  localparam logic [1:0] CODE_TCP  = 2'd2;
  localparam logic [1:0] CODE_UDP  = 2'd3;

  // Rule field size codes
  localparam logic [1:0] SIZE_ONE = 2'd0;
  localparam logic [1:0] SIZE_TWO = 2'd1;

  // Header lengths and byte positions
  localparam logic [4:0] LEN_SCTP     = 5'd12;
  localparam logic [4:0] LEN_TCP      = 5'd20;
  localparam logic [4:0] LEN_UDP      = 5'd8;
  localparam logic [4:0] LEN_NONE     = 5'd0;
  localparam int unsigned V4_MIN_LEN  = 20;
  localparam int unsigned V6_MIN_LEN  = 40;
  localparam int unsigned V6_NXT_POS  = 6;
  localparam int unsigned V4_PROTO_POS = 9;
  localparam int unsigned ENCAP_SKIP  = 8;

  typedef struct packed {
    logic [8:0]  where;
    logic [31:0] mask;
    logic [31:0] value;
  } rule_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] nxt_type;
    logic [7:0] l4_proto;
    logic       failed;
    logic       v6;
    logic       inner_sctp;
  } hdr_t;

  function automatic logic is_ext_hdr(logic [7:0] t);
    logic res;
    case (t)
      EH_HOPOPT, EH_ROUTING, EH_FRAG, EH_ESP, EH_AH, EH_DSTOPT,
      EH_MOBILITY, EH_HIP, EH_SHIM6, EH_EXP1, EH_EXP2: res = 1'b1;
      default: res = 1'b0;
    endcase
    return res;
  endfunction

  function automatic logic [4:0] hdr_len(logic [7:0] proto);
    logic [4:0] res;
    case (proto)
      PROTO_SCTP: res = LEN_SCTP;
      PROTO_TCP:  res = LEN_TCP;
      PROTO_UDP:  res = LEN_UDP;
      default:    res = LEN_NONE;
    endcase
    return res;
  endfunction

  function automatic logic [1:0] rule_code(logic [7:0] proto);
    logic [1:0] res;
    case (proto)
      PROTO_SCTP: res = CODE_SCTP;
      PROTO_TCP:  res = CODE_TCP;
      PROTO_UDP:  res = CODE_UDP;
      default:    res = CODE_OFF;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/lhfm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for packet bytes in and match results out.
// No dependencies.
interface lhfm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       first_byte;
  logic       last_byte;
  logic       is_ipv6;
  logic       inner_is_sctp;

  modport source (output valid, pkt_byte, first_byte, last_byte, is_ipv6, inner_is_sctp,
                  input ready);
  modport sink (input valid, pkt_byte, first_byte, last_byte, is_ipv6, inner_is_sctp,
                output ready);
endinterface

interface lhfm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink (input valid, matched, output ready);
endinterface

// ===== sv/l4_header_field_matcher_core.sv =====
`timescale 1ns / 1ps
// Top level of the L4 header field matcher: register file, byte parser, result stage.
// Depends on lhfm_pkg, lhfm_if, lhfm_cfg, lhfm_parser and lhfm_decide.
//
//   Channel  | Dir | Handshake          | Payload
//   ---------+-----+--------------------+----------------------------------------------
//   in_i     | in  | valid/ready        | pkt_byte, first_byte, last_byte, is_ipv6,
//            |     |                    | inner_is_sctp
//   out_o    | out | valid/ready        | matched (one transfer per last byte)
//   APB      | in  | psel/penable/pready| six rule registers at 8-byte steps
//
// One byte is taken every cycle while the input is not blocked (see below). The parser
// state updates at the accepting edge; for a last byte the decision is formed from that
// state in the next cycle and lands in the output register once that register is free.
// A pending decision blocks new input only while the output register is stalled.
// Reset is asynchronous, active low; no clearing pass is needed.
module l4_header_field_matcher_core #(
  parameter int unsigned MaxPktBytes = lhfm_pkg::MAX_PACKET_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lhfm_in_if.sink                         in_i,
  lhfm_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lhfm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lhfm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lhfm_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned IdxW = $clog2(MaxPktBytes + 2);

  lhfm_pkg::rule_t rules [lhfm_pkg::NUM_RULES];
  lhfm_pkg::hdr_t  hdr;
  logic [IdxW-1:0] len;
  logic [IdxW-1:0] l4_start;
  logic [IdxW-1:0] next_pos;
  logic [lhfm_pkg::GATHER_W-1:0] gather [lhfm_pkg::NUM_RULES];
  logic [lhfm_pkg::GATHER_W-1:0] encap_gather [lhfm_pkg::NUM_RULES];
  logic done;
  logic take;
  logic out_free;
  logic acc;
  logic out_valid;
  logic matched;

  assign in_i.ready = ~done | out_free;
  assign acc        = in_i.valid & in_i.ready;

  lhfm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rules_o (rules)
  );

  lhfm_parser #(
    .MaxPktBytes (MaxPktBytes)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .acc_i           (acc),
    .pkt_byte_i      (in_i.pkt_byte),
    .first_byte_i    (in_i.first_byte),
    .last_byte_i     (in_i.last_byte),
    .is_ipv6_i       (in_i.is_ipv6),
    .inner_is_sctp_i (in_i.inner_is_sctp),
    .take_i          (take),
    .rules_i         (rules),
    .hdr_o           (hdr),
    .len_o           (len),
    .l4_start_o      (l4_start),
    .next_pos_o      (next_pos),
    .gather_o        (gather),
    .encap_gather_o  (encap_gather),
    .done_o          (done)
  );

  lhfm_decide #(
    .MaxPktBytes (MaxPktBytes)
  ) u_decide (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .done_i         (done),
    .hdr_i          (hdr),
    .len_i          (len),
    .l4_start_i     (l4_start),
    .next_pos_i     (next_pos),
    .gather_i       (gather),
    .encap_gather_i (encap_gather),
    .rules_i        (rules),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_valid),
    .matched_o      (matched),
    .out_free_o     (out_free),
    .take_o         (take)
  );

  assign out_o.valid   = out_valid;
  assign out_o.matched = matched;

endmodule

// ===== sv/lhfm_cfg.sv =====
`timescale 1ns / 1ps
// APB-style register file holding the three match rules.
// Depends on lhfm_pkg.
module lhfm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lhfm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lhfm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lhfm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output lhfm_pkg::rule_t                     rules_o [lhfm_pkg::NUM_RULES]
);

  logic [2:0] reg_idx;
  logic [1:0] rule_idx;
  logic       wr_en;

  lhfm_pkg::rule_t rules_q [lhfm_pkg::NUM_RULES];

  // Registers sit on 8-byte boundaries; even index is "where", odd is "test"
  assign reg_idx  = paddr[5:3];
  assign rule_idx = reg_idx[2:1];
  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite & pready
                  & (reg_idx < 3'(lhfm_pkg::NUM_CFG_REGS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < lhfm_pkg::NUM_RULES; r++) begin
        rules_q[r] <= '0;
      end
    end else if (wr_en) begin
      if (reg_idx[0]) begin
        rules_q[rule_idx].mask  <= pwdata[63:32];
        rules_q[rule_idx].value <= pwdata[31:0];
      end else begin
        rules_q[rule_idx].where <= pwdata[8:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < 3'(lhfm_pkg::NUM_CFG_REGS)) begin
      if (reg_idx[0]) begin
        prdata = {rules_q[rule_idx].mask, rules_q[rule_idx].value};
      end else begin
        prdata = {55'b0, rules_q[rule_idx].where};
      end
    end
  end

  assign rules_o = rules_q;

endmodule

// ===== sv/lhfm_parser.sv =====
`timescale 1ns / 1ps
// Per-byte header walker: tracks byte position, locates the L4 header and gathers rule fields.
// Depends on lhfm_pkg.
module lhfm_parser #(
  parameter int unsigned MaxPktBytes = lhfm_pkg::MAX_PACKET_BYTES,
  localparam int unsigned IdxW = $clog2(MaxPktBytes + 2)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              acc_i,
  input  logic [7:0]                        pkt_byte_i,
  input  logic                              first_byte_i,
  input  logic                              last_byte_i,
  input  logic                              is_ipv6_i,
  input  logic                              inner_is_sctp_i,
  input  logic                              take_i,
  input  lhfm_pkg::rule_t                   rules_i [lhfm_pkg::NUM_RULES],
  output lhfm_pkg::hdr_t                    hdr_o,
  output logic [IdxW-1:0]                   len_o,
  output logic [IdxW-1:0]                   l4_start_o,
  output logic [IdxW-1:0]                   next_pos_o,
  output logic [lhfm_pkg::GATHER_W-1:0]     gather_o [lhfm_pkg::NUM_RULES],
  output logic [lhfm_pkg::GATHER_W-1:0]     encap_gather_o [lhfm_pkg::NUM_RULES],
  output logic                              done_o
);

  localparam logic [IdxW-1:0]  MaxIdx  = IdxW'(MaxPktBytes);
  localparam logic [IdxW-1:0]  PosSat  = IdxW'(MaxPktBytes + 1);
  localparam logic [IdxW+11:0] PosMax  = (IdxW + 12)'(MaxPktBytes);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [IdxW-1:0] l4s_q, l4s_d;
  lhfm_pkg::hdr_t  hdr_q, hdr_d;
  logic [lhfm_pkg::GATHER_W-1:0] fg_q [lhfm_pkg::NUM_RULES];
  logic [lhfm_pkg::GATHER_W-1:0] fg_d [lhfm_pkg::NUM_RULES];
  logic [lhfm_pkg::GATHER_W-1:0] eg_q [lhfm_pkg::NUM_RULES];
  logic [lhfm_pkg::GATHER_W-1:0] eg_d [lhfm_pkg::NUM_RULES];
  logic            in_pkt_q;
  logic            done_q, done_d;
  logic            new_pkt;
  logic [IdxW+11:0] pos_sum;

  // Place byte b into gather g when idx falls inside the rule's field at base
  function automatic logic [31:0] capture(logic [31:0] g, logic [8:0] where,
                                          logic [IdxW:0] base, logic [IdxW-1:0] idx,
                                          logic [7:0] b);
    logic [IdxW:0] start;
    logic [IdxW:0] diff;
    logic [2:0]    n;
    logic [1:0]    k;
    logic [1:0]    lane;
    logic [31:0]   res;
    start = base + (IdxW + 1)'(where[6:2]);
    diff  = {1'b0, idx} - start;
    if (where[1:0] == lhfm_pkg::SIZE_ONE) begin
      n = 3'd1;
    end else if (where[1:0] == lhfm_pkg::SIZE_TWO) begin
      n = 3'd2;
    end else begin
      n = 3'd4;
    end
    k    = diff[1:0];
    lane = 2'(n - 3'd1 - {1'b0, k});
    res  = g;
    if (({1'b0, idx} >= start) && (diff < (IdxW + 1)'(n))) begin
      res = g | ({24'b0, b} << {lane, 3'b000});
    end
    return res;
  endfunction

  assign new_pkt = first_byte_i | ~in_pkt_q;

  always_comb begin
    if (new_pkt) begin
      idx_d            = '0;
      pos_d            = '0;
      l4s_d            = '0;
      hdr_d            = '0;
      hdr_d.phase      = lhfm_pkg::PH_IP;
      hdr_d.v6         = is_ipv6_i;
      hdr_d.inner_sctp = inner_is_sctp_i;
      for (int r = 0; r < lhfm_pkg::NUM_RULES; r++) begin
        fg_d[r] = '0;
        eg_d[r] = '0;
      end
    end else begin
      idx_d = idx_q;
      pos_d = pos_q;
      l4s_d = l4s_q;
      hdr_d = hdr_q;
      fg_d  = fg_q;
      eg_d  = eg_q;
    end
    pos_sum = (IdxW + 12)'(pos_d) + (IdxW + 12)'({pkt_byte_i, 3'b000});

    // Bytes past the size limit leave the state alone
    if (idx_d < MaxIdx) begin
      if (!hdr_d.v6) begin
        if (idx_d == '0) begin
          l4s_d       = IdxW'({pkt_byte_i[3:0], 2'b00});
          hdr_d.phase = lhfm_pkg::PH_L4;
        end
        if (idx_d == IdxW'(lhfm_pkg::V4_PROTO_POS)) begin
          hdr_d.l4_proto = pkt_byte_i;
        end
      end else begin
        if (idx_d == '0) begin
          hdr_d.phase = lhfm_pkg::PH_WALK;
          pos_d       = IdxW'(lhfm_pkg::V6_MIN_LEN);
          pos_sum     = (IdxW + 12)'(pos_d) + (IdxW + 12)'({pkt_byte_i, 3'b000});
        end
        if (idx_d == IdxW'(lhfm_pkg::V6_NXT_POS)) begin
          hdr_d.nxt_type = pkt_byte_i;
        end
        if (hdr_d.phase == lhfm_pkg::PH_WALK && idx_d == pos_d) begin
          if (lhfm_pkg::is_ext_hdr(hdr_d.nxt_type)) begin
            if (hdr_d.nxt_type == lhfm_pkg::EH_FRAG) begin
              hdr_d.failed = 1'b1;
              hdr_d.phase  = lhfm_pkg::PH_DEAD;
            end else begin
              hdr_d.nxt_type = pkt_byte_i;
              hdr_d.phase    = lhfm_pkg::PH_EXTLEN;
            end
          end else begin
            l4s_d          = pos_d;
            hdr_d.l4_proto = hdr_d.nxt_type;
            hdr_d.phase    = lhfm_pkg::PH_L4;
          end
        end else if (hdr_d.phase == lhfm_pkg::PH_EXTLEN &&
                     {1'b0, idx_d} == {1'b0, pos_d} + (IdxW + 1)'(1)) begin
          if (pkt_byte_i == 8'd0) begin
            hdr_d.failed = 1'b1;
            hdr_d.phase  = lhfm_pkg::PH_DEAD;
          end else begin
            // Saturate past the size limit: such a position can never be reached
            pos_d       = (pos_sum > PosMax) ? PosSat : pos_sum[IdxW-1:0];
            hdr_d.phase = lhfm_pkg::PH_WALK;
          end
        end
      end
      if (hdr_d.phase == lhfm_pkg::PH_L4) begin
        for (int r = 0; r < lhfm_pkg::NUM_RULES; r++) begin
          fg_d[r] = capture(fg_d[r], rules_i[r].where, {1'b0, l4s_d}, idx_d, pkt_byte_i);
          eg_d[r] = capture(eg_d[r], rules_i[r].where,
                            {1'b0, l4s_d} + (IdxW + 1)'(lhfm_pkg::ENCAP_SKIP),
                            idx_d, pkt_byte_i);
        end
      end
      idx_d = idx_d + IdxW'(1);
    end
  end

  // Decision pending until the result register takes it
  always_comb begin
    if (acc_i) begin
      done_d = last_byte_i;
    end else begin
      done_d = done_q & ~take_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pos_q       <= '0;
      l4s_q       <= '0;
      hdr_q       <= '0;
      in_pkt_q    <= 1'b0;
      done_q      <= 1'b0;
      for (int r = 0; r < lhfm_pkg::NUM_RULES; r++) begin
        fg_q[r] <= '0;
        eg_q[r] <= '0;
      end
    end else begin
      done_q <= done_d;
      if (acc_i) begin
        idx_q    <= idx_d;
        pos_q    <= pos_d;
        l4s_q    <= l4s_d;
        hdr_q    <= hdr_d;
        fg_q     <= fg_d;
        eg_q     <= eg_d;
        in_pkt_q <= ~last_byte_i;
      end
    end
  end

  assign hdr_o          = hdr_q;
  assign len_o          = idx_q;
  assign l4_start_o     = l4s_q;
  assign next_pos_o     = pos_q;
  assign gather_o       = fg_q;
  assign encap_gather_o = eg_q;
  assign done_o         = done_q;

endmodule

// ===== sv/lhfm_decide.sv =====
`timescale 1ns / 1ps
// End-of-packet header checks and rule comparison, feeding the registered result stage.
// Depends on lhfm_pkg.
module lhfm_decide #(
  parameter int unsigned MaxPktBytes = lhfm_pkg::MAX_PACKET_BYTES,
  localparam int unsigned IdxW = $clog2(MaxPktBytes + 2)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              done_i,
  input  lhfm_pkg::hdr_t                    hdr_i,
  input  logic [IdxW-1:0]                   len_i,
  input  logic [IdxW-1:0]                   l4_start_i,
  input  logic [IdxW-1:0]                   next_pos_i,
  input  logic [lhfm_pkg::GATHER_W-1:0]     gather_i [lhfm_pkg::NUM_RULES],
  input  logic [lhfm_pkg::GATHER_W-1:0]     encap_gather_i [lhfm_pkg::NUM_RULES],
  input  lhfm_pkg::rule_t                   rules_i [lhfm_pkg::NUM_RULES],
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              matched_o,
  output logic                              out_free_o,
  output logic                              take_o
);

  logic            any_rule;
  logic            ok;
  logic            encap;
  logic            result;
  logic [2:0]      phase;
  logic [IdxW-1:0] l4s;
  logic [7:0]      proto;
  logic [1:0]      code;
  logic [31:0]     x;
  logic            out_valid_q;
  logic            matched_q;

  always_comb begin
    any_rule = 1'b0;
    ok       = 1'b1;
    phase    = hdr_i.phase;
    l4s      = l4_start_i;
    proto    = hdr_i.l4_proto;
    x        = '0;
    for (int r = 0; r < lhfm_pkg::NUM_RULES; r++) begin
      if (rules_i[r].where[8:7] != lhfm_pkg::CODE_OFF) begin
        any_rule = 1'b1;
      end
    end
    if (hdr_i.failed) begin
      ok = 1'b0;
    end
    if (!hdr_i.v6) begin
      if (len_i < IdxW'(lhfm_pkg::V4_MIN_LEN)) begin
        ok = 1'b0;
      end
    end else begin
      if (len_i < IdxW'(lhfm_pkg::V6_MIN_LEN)) begin
        ok = 1'b0;
      end
      // Header chain ending exactly at the packet end
      if (phase == lhfm_pkg::PH_WALK) begin
        if (next_pos_i != len_i || lhfm_pkg::is_ext_hdr(hdr_i.nxt_type)) begin
          ok = 1'b0;
        end else begin
          l4s   = next_pos_i;
          proto = hdr_i.nxt_type;
          phase = lhfm_pkg::PH_L4;
        end
      end
    end
    if (phase != lhfm_pkg::PH_L4) begin
      ok = 1'b0;
    end
    if ({1'b0, l4s} + (IdxW + 1)'(lhfm_pkg::hdr_len(proto)) > {1'b0, len_i}) begin
      ok = 1'b0;
    end
    encap = (proto == lhfm_pkg::PROTO_UDP) & hdr_i.inner_sctp;
    if (encap && ({1'b0, l4s} + (IdxW + 1)'(lhfm_pkg::ENCAP_SKIP)
                  + (IdxW + 1)'(lhfm_pkg::LEN_SCTP) > {1'b0, len_i})) begin
      ok = 1'b0;
    end
    code = encap ? lhfm_pkg::CODE_SCTP : lhfm_pkg::rule_code(proto);
    for (int r = 0; r < lhfm_pkg::NUM_RULES; r++) begin
      if (rules_i[r].where[8:7] != lhfm_pkg::CODE_OFF && rules_i[r].where[8:7] == code) begin
        x = encap ? encap_gather_i[r] : gather_i[r];
        if (rules_i[r].mask != '0) begin
          x = x & rules_i[r].mask;
        end
        if (x != rules_i[r].value) begin
          ok = 1'b0;
        end
      end
    end
    result = ~any_rule | ok;
  end

  assign out_free_o = ~out_valid_q | out_ready_i;
  assign take_o     = done_i & out_free_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      matched_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule

// ===== sv/lhfm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the matcher's byte and result channels, bound to the top level.
// Depends on l4_header_field_matcher_core.
module lhfm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic matched_i
);

  logic in_last_xfer;

  assign in_last_xfer = in_valid_i & in_ready_i & in_last_i;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(matched_i))
    else $error("result changed or dropped while stalled");

  // A fresh result must be preceded by a last-byte transfer
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_last_xfer, 2))
    else $error("result appeared without a last-byte transfer");

  // With a free result register the pending decision lands in it without a stall
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_xfer ##1 (!out_valid_i || out_ready_i) |=> out_valid_i)
    else $error("result not delivered after last byte");

  // Pending decision behind a stalled result blocks input
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_xfer ##1 (out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input taken while a decision was waiting");

endmodule

bind l4_header_field_matcher_core lhfm_checker u_lhfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_byte),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .matched_i   (out_o.matched)
);
